### design/assert_macros.svh
// Assertion macros included by the top level of the CSV tokenizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, cond, msg)
`endif

`endif

### design/csvti_pkg.sv
// Types, character codes and field classification functions of the CSV tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package csvti_pkg;

    typedef enum logic [2:0] {
        SC_EMPTY  = 3'd0,
        SC_SIGN   = 3'd1,
        SC_INT    = 3'd2,
        SC_FLOAT  = 3'd3,
        SC_STRING = 3'd4,
        SC_IDLE   = 3'd5
    } scan_t;

    localparam logic [1:0] TY_EMPTY  = 2'd0;
    localparam logic [1:0] TY_INT    = 2'd1;
    localparam logic [1:0] TY_FLOAT  = 2'd2;
    localparam logic [1:0] TY_STRING = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [5:0] COL_INDEX_MAX = 6'd63;
    localparam logic [5:0] REPORT_LIMIT  = 6'd32;

    function automatic scan_t scan_next(input scan_t s, input logic [7:0] b);
        logic  digit;
        scan_t r;
        digit = (b >= CH_ZERO) && (b <= CH_NINE);
        case (s)
            SC_EMPTY, SC_IDLE: begin
                if (b == CH_PLUS || b == CH_MINUS) r = SC_SIGN;
                else if (digit)                    r = SC_INT;
                else if (b == CH_DOT)              r = SC_FLOAT;
                else                               r = SC_STRING;
            end
            SC_SIGN, SC_INT: begin
                if (digit)            r = SC_INT;
                else if (b == CH_DOT) r = SC_FLOAT;
                else                  r = SC_STRING;
            end
            SC_FLOAT: r = digit ? SC_FLOAT : SC_STRING;
            default:  r = SC_STRING;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] scan_class(input scan_t s);
        logic [1:0] t;
        case (s)
            SC_SIGN, SC_INT: t = TY_INT;
            SC_FLOAT:        t = TY_FLOAT;
            SC_STRING:       t = TY_STRING;
            default:         t = TY_EMPTY;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

### design/csv_field_splitter_type_inference_unit.sv
// Top level of the CSV tokenizer with per-column type inference.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Takes one byte of CSV text per transfer and returns one result per data field,
// then one column type report per column when end of input arrives. Text bytes
// are accepted at one per cycle while the result register drains; at most one
// result follows each byte. The column types live in a small synchronous memory
// that is read when a field ends and written back the next cycle, with forwarding
// when the following field hits the same column. After the end-of-input transfer,
// each reported column passes through a read state and a report state, and no
// byte is accepted until the report ends. Afterwards the parsing state is back
// to its reset value and every type-table entry is marked invalid.
module csv_field_splitter_type_inference_unit #(
    parameter int MAX_COLUMNS = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_end_of_input,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_report_kind,
    output logic [4:0]      m_column,
    output logic [1:0]      m_type_code,
    output logic            m_extra_column,
    output logic            m_last
);
    import csvti_pkg::*;

    localparam int         AW       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam logic [5:0] MAX_COLS = 6'(MAX_COLUMNS);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_RD,
        ST_WR
    } state_t;

    state_t     state_reg, state_next;
    logic       in_header_reg, in_header_next;
    logic       quoted_reg, quoted_next;
    logic       done_reg, done_next;
    logic [5:0] col_count_reg, col_count_next;
    logic [5:0] col_idx_reg, col_idx_next;
    scan_t      scan_reg, scan_next_s;
    logic [5:0] rpt_idx_reg, rpt_idx_next;

    logic       m_valid_reg, m_valid_next;
    logic       m_kind_reg, m_kind_next;
    logic [4:0] m_column_reg, m_column_next;
    logic [1:0] m_type_reg, m_type_next;
    logic       m_extra_reg, m_extra_next;
    logic       m_last_reg, m_last_next;

    logic          wr_pend_reg, wr_pend_next;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    logic [1:0]    wr_type_reg, wr_type_next;

    logic [1:0]    type_mem [MAX_COLUMNS];
    logic          entry_valid_reg [MAX_COLUMNS];
    logic [1:0]    rd_data_reg;
    logic          rd_valid_reg;
    logic          fwd_hit_reg, fwd_hit_next;
    logic [1:0]    fwd_data_reg, fwd_data_next;

    logic          in_xfer, out_free, emit, in_range, rd_en, wr_en, clear_all;
    logic [AW-1:0] rd_addr;
    logic [1:0]    emit_class, rd_old, wr_merged;
    logic [5:0]    rpt_count;
    logic          quote_toggled;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_RUN) && out_free;
    assign in_xfer   = s_valid && s_ready;
    assign rpt_count = (col_count_reg > REPORT_LIMIT) ? REPORT_LIMIT : col_count_reg;

    assign rd_old    = fwd_hit_reg ? fwd_data_reg : (rd_valid_reg ? rd_data_reg : TY_EMPTY);
    assign wr_en     = wr_pend_reg && (wr_type_reg > rd_old);
    assign wr_merged = wr_en ? wr_type_reg : rd_old;

    assign in_range   = (col_idx_reg < col_count_reg) && (col_idx_reg < MAX_COLS);
    assign emit_class = scan_class(scan_reg);
    assign quote_toggled = quoted_reg ^ (s_data_byte == CH_QUOTE);

    always_comb begin
        state_next     = state_reg;
        in_header_next = in_header_reg;
        quoted_next    = quoted_reg;
        done_next      = done_reg;
        col_count_next = col_count_reg;
        col_idx_next   = col_idx_reg;
        scan_next_s    = scan_reg;
        rpt_idx_next   = rpt_idx_reg;
        emit           = 1'b0;
        clear_all      = 1'b0;

        if (in_xfer) begin
            if (s_end_of_input) begin
                emit         = !in_header_reg && (scan_reg != SC_IDLE) && !done_reg;
                state_next   = ST_RD;
                rpt_idx_next = '0;
            end else if (s_data_byte == CH_LF) begin
                emit           = !in_header_reg && !done_reg;
                in_header_next = 1'b0;
                quoted_next    = 1'b0;
                done_next      = 1'b0;
                col_idx_next   = '0;
                scan_next_s    = SC_IDLE;
            end else if (in_header_reg) begin
                if (!done_reg) begin
                    if (s_data_byte == CH_NUL) begin
                        done_next = 1'b1;
                    end else if (s_data_byte == CH_COMMA && col_count_reg < MAX_COLS) begin
                        col_count_next = col_count_reg + 6'd1;
                    end
                end
            end else if (!done_reg) begin
                if (s_data_byte == CH_CR || s_data_byte == CH_NUL) begin
                    emit        = 1'b1;
                    done_next   = 1'b1;
                    scan_next_s = SC_EMPTY;
                end else begin
                    quoted_next = quote_toggled;
                    if (s_data_byte == CH_COMMA && !quote_toggled) begin
                        emit        = 1'b1;
                        scan_next_s = SC_EMPTY;
                        if (col_idx_reg < COL_INDEX_MAX) begin
                            col_idx_next = col_idx_reg + 6'd1;
                        end
                    end else begin
                        scan_next_s = scan_next(scan_reg, s_data_byte);
                    end
                end
            end
        end

        case (state_reg)
            ST_RD: state_next = ST_WR;
            ST_WR: begin
                if (out_free) begin
                    if (rpt_idx_reg + 6'd1 == rpt_count) begin
                        state_next     = ST_RUN;
                        clear_all      = 1'b1;
                        in_header_next = 1'b1;
                        col_count_next = 6'd1;
                        quoted_next    = 1'b0;
                        done_next      = 1'b0;
                        col_idx_next   = '0;
                        scan_next_s    = SC_EMPTY;
                    end else begin
                        state_next   = ST_RD;
                        rpt_idx_next = rpt_idx_reg + 6'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = col_idx_reg[AW-1:0];
        if (state_reg == ST_RD) begin
            rd_en   = 1'b1;
            rd_addr = rpt_idx_reg[AW-1:0];
        end else if (in_xfer && emit && in_range) begin
            rd_en = 1'b1;
        end
        wr_pend_next  = in_xfer && emit && in_range && (emit_class != TY_EMPTY);
        wr_addr_next  = col_idx_reg[AW-1:0];
        wr_type_next  = emit_class;
        fwd_hit_next  = rd_en && wr_pend_reg && (wr_addr_reg == rd_addr);
        fwd_data_next = wr_merged;
    end

    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        m_kind_next   = m_kind_reg;
        m_column_next = m_column_reg;
        m_type_next   = m_type_reg;
        m_extra_next  = m_extra_reg;
        m_last_next   = m_last_reg;
        if (in_xfer && emit) begin
            m_valid_next  = 1'b1;
            m_kind_next   = 1'b0;
            m_column_next = in_range ? col_idx_reg[4:0] : 5'd0;
            m_type_next   = emit_class;
            m_extra_next  = !in_range;
            m_last_next   = !s_end_of_input;
        end else if (state_reg == ST_WR && out_free) begin
            m_valid_next  = 1'b1;
            m_kind_next   = 1'b1;
            m_column_next = rpt_idx_reg[4:0];
            m_type_next   = (rd_old == TY_EMPTY) ? TY_STRING : rd_old;
            m_extra_next  = 1'b0;
            m_last_next   = (rpt_idx_reg + 6'd1 == rpt_count);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RUN;
            in_header_reg <= 1'b1;
            quoted_reg    <= 1'b0;
            done_reg      <= 1'b0;
            col_count_reg <= 6'd1;
            col_idx_reg   <= '0;
            scan_reg      <= SC_EMPTY;
            rpt_idx_reg   <= '0;
            m_valid_reg   <= 1'b0;
            wr_pend_reg   <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            in_header_reg <= in_header_next;
            quoted_reg    <= quoted_next;
            done_reg      <= done_next;
            col_count_reg <= col_count_next;
            col_idx_reg   <= col_idx_next;
            scan_reg      <= scan_next_s;
            rpt_idx_reg   <= rpt_idx_next;
            m_valid_reg   <= m_valid_next;
            wr_pend_reg   <= wr_pend_next;
            if (rd_en) begin
                fwd_hit_reg <= fwd_hit_next;
            end
        end
        m_kind_reg   <= m_kind_next;
        m_column_reg <= m_column_next;
        m_type_reg   <= m_type_next;
        m_extra_reg  <= m_extra_next;
        m_last_reg   <= m_last_next;
        wr_addr_reg  <= wr_addr_next;
        wr_type_reg  <= wr_type_next;
        if (rd_en) begin
            fwd_data_reg <= fwd_data_next;
        end
    end

    // The type memory reads before it writes; forwarding covers a same-entry hit.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            type_mem[wr_addr_reg] <= wr_type_reg;
        end
        if (rd_en) begin
            rd_data_reg <= type_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear_all) begin
            for (int i = 0; i < MAX_COLUMNS; i++) begin
                entry_valid_reg[i] <= 1'b0;
            end
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                entry_valid_reg[wr_addr_reg] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= entry_valid_reg[rd_addr];
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_report_kind  = m_kind_reg;
    assign m_column       = m_column_reg;
    assign m_type_code    = m_type_reg;
    assign m_extra_column = m_extra_reg;
    assign m_last         = m_last_reg;

    `ASSERT_NEVER(a_no_input_in_report, aclk, aresetn, (state_reg != ST_RUN) && s_ready, "input taken during the column report")
    `ASSERT_IMPLY(a_wr_after_xfer, aclk, aresetn, wr_pend_reg |-> $past(in_xfer), "table update without a preceding transfer")
    `ASSERT_NEVER(a_col_count_range, aclk, aresetn, (col_count_reg == 6'd0) || (col_count_reg > MAX_COLS), "column count out of range")
    `ASSERT_NEVER(a_report_not_extra, aclk, aresetn, m_valid_reg && m_kind_reg && (m_extra_reg || m_type_reg == TY_EMPTY), "column report flagged extra or empty")

endmodule

`default_nettype wire
